// ===== design/p2hem_pkg.sv =====
// Shared constants and types for the pow2 half-exponent modular power block.
`timescale 1ns / 1ps

package p2hem_pkg;

    // Result width and the prime modulus
    localparam int RES_W = 30;
    localparam logic [RES_W-1:0] PRIME_MOD = 30'd1000000007;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 31;
    localparam int PROD_W = 2 * MUL_W;

    // Barrett reciprocal: floor(2^60 / PRIME_MOD)
    localparam logic [MUL_W-1:0] BARRETT_M = 31'd1152921496;

    // Request to the shared multiplier
    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] op_a;
        logic [MUL_W-1:0] op_b;
    } mul_req_t;

endpackage

// ===== design/p2hem_mul.sv =====
// Shared registered 31x31 multiplier used for squaring and Barrett reduction.
`timescale 1ns / 1ps

module p2hem_mul (
    input  logic                          aclk,
    input  p2hem_pkg::mul_req_t           req,
    output logic [p2hem_pkg::PROD_W-1:0]  prod
);
    import p2hem_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/pow2_half_exponent_mod_prime.sv =====
// Top level: 2^(a/2) mod 1000000007 by left-to-right square-and-double.
// Usage:
//   Input channel (s_valid/s_ready/s_exponent_value) carries one integer a.
//   Only the low INPUT_BITS bits of a are used. Result channel
//   (m_valid/m_ready/m_power_result) returns one value per input: 0 when a is
//   odd, otherwise 2^(a/2) mod 1000000007.
// Operation:
//   The exponent h = a/2 is walked from its top bit down, one bit per pass
//   through a sequence of states that squares the accumulator and reduces
//   it on one shared 31x31 multiplier (square, Barrett quotient,
//   quotient*prime), then subtracts, corrects twice and doubles modulo the
//   prime when the bit is set. An even a makes one pass per bit of h
//   (INPUT_BITS-1 passes) before m_valid; an odd a skips the passes.
//   s_ready is high only while the sequencer is idle, so one item is in work
//   at a time: a new item is taken only once the last has left the sequencer.
// Reset and stalls:
//   aresetn (synchronous, active low) returns the sequencer to idle and
//   drops m_valid. A finished result sits in the output register until its
//   transfer; a new item may be taken meanwhile, and the block then holds
//   its next result, with s_ready low, until the output register frees up.
`timescale 1ns / 1ps

module pow2_half_exponent_mod_prime #(
    parameter int INPUT_BITS = 31
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [INPUT_BITS-1:0]         s_exponent_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [p2hem_pkg::RES_W-1:0]   m_power_result
);
    import p2hem_pkg::*;

    localparam int HALF_BITS = INPUT_BITS - 1;
    localparam int CNT_W     = (HALF_BITS > 1) ? $clog2(HALF_BITS) : 1;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL_SQ = 9'b000000010,  // acc * acc
        ST_MUL_Q  = 9'b000000100,  // (x >> 29) * M
        ST_MUL_QP = 9'b000001000,  // q * prime
        ST_SUB    = 9'b000010000,  // r = x - q*prime
        ST_FIX1   = 9'b000100000,  // first correction
        ST_FIX2   = 9'b001000000,  // second correction, write acc
        ST_DBL    = 9'b010000000,  // conditional doubling mod prime
        ST_FINISH = 9'b100000000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    logic [HALF_BITS-1:0] half_reg;     // remaining exponent bits, MSB first
    logic [CNT_W-1:0]     cnt_reg;      // bits left after the current one
    logic [RES_W-1:0]     acc_reg;      // running power, always < prime
    logic                 odd_reg;
    logic [31:0]          xlow_reg;     // low word of the square
    logic [31:0]          r_reg;        // partially reduced square, < 3*prime

    logic                 m_valid_reg;
    logic [RES_W-1:0]     m_power_result_reg;

    mul_req_t             mul_req;
    logic [PROD_W-1:0]    prod;

    logic [31:0]          r_sub;
    logic                 r_ge;
    logic [RES_W:0]       dbl;
    logic [RES_W:0]       dbl_sub;
    logic                 dbl_ge;
    logic                 out_free;

    p2hem_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // Operand selection for the shared multiplier
    always_comb begin
        mul_req.en   = 1'b0;
        mul_req.op_a = {1'b0, acc_reg};
        mul_req.op_b = {1'b0, acc_reg};
        unique case (state_reg)
            ST_MUL_SQ: begin
                mul_req.en = 1'b1;
            end
            ST_MUL_Q: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = prod[59:29];
                mul_req.op_b = BARRETT_M;
            end
            ST_MUL_QP: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = prod[61:31];
                mul_req.op_b = {1'b0, PRIME_MOD};
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // Correction and doubling arithmetic
    assign r_sub   = r_reg - {2'b00, PRIME_MOD};
    assign r_ge    = (r_reg >= {2'b00, PRIME_MOD});
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_sub = dbl - {1'b0, PRIME_MOD};
    assign dbl_ge  = (dbl >= {1'b0, PRIME_MOD});

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_exponent_value[0] ? ST_FINISH : ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: state_next = ST_MUL_Q;
            ST_MUL_Q:  state_next = ST_MUL_QP;
            ST_MUL_QP: state_next = ST_SUB;
            ST_SUB:    state_next = ST_FIX1;
            ST_FIX1:   state_next = ST_FIX2;
            ST_FIX2:   state_next = ST_DBL;
            ST_DBL: begin
                state_next = (cnt_reg == '0) ? ST_FINISH : ST_MUL_SQ;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    half_reg <= s_exponent_value[INPUT_BITS-1:1];
                    cnt_reg  <= CNT_W'(HALF_BITS - 1);
                    acc_reg  <= RES_W'(1);
                    odd_reg  <= s_exponent_value[0];
                end
            end
            ST_MUL_Q: begin
                xlow_reg <= prod[31:0];
            end
            ST_SUB: begin
                r_reg <= xlow_reg - prod[31:0];
            end
            ST_FIX1: begin
                if (r_ge) begin
                    r_reg <= r_sub;
                end
            end
            ST_FIX2: begin
                acc_reg <= r_ge ? r_sub[RES_W-1:0] : r_reg[RES_W-1:0];
            end
            ST_DBL: begin
                if (half_reg[HALF_BITS-1]) begin
                    acc_reg <= dbl_ge ? dbl_sub[RES_W-1:0] : dbl[RES_W-1:0];
                end
                half_reg <= half_reg << 1;
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_power_result_reg <= odd_reg ? '0 : acc_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_power_result = m_power_result_reg;

endmodule
